>>> rtl/sdad_pkg.sv
package sdad_pkg;

  localparam int DIM_DEF = 4096;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DOT   = 2'd2,
    OP_ADD   = 2'd3
  } sdad_op_t;

  typedef enum logic {
    KIND_WEIGHT = 1'b0,
    KIND_DOT    = 1'b1
  } sdad_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_EXEC
  } sdad_state_t;

  typedef struct packed {
    sdad_op_t           op;
    logic        [12:0] index;
    logic signed [31:0] value;
    logic signed [31:0] scale;
    logic               last;
  } sdad_in_t;

  typedef struct packed {
    sdad_kind_t         kind;
    logic signed [47:0] result;
  } sdad_out_t;

endpackage

>>> rtl/sparse_dense_dot_axpy.sv
// Channel  Ports                    Direction  Word
// input    start, busy, in_word     in         sdad_in_t: op, index, value, scale, last
// result   out_strobe, out_word     out        sdad_out_t: kind, result
//
// A word is taken when start is high and busy is low. Each item passes read,
// multiply and execute in turn; while idle, or once the last one is in execute,
// a new word can be taken. The weight memory's registered read and the 32x32
// multiplier set these stages. The result is registered from execute and shown,
// for one cycle, on out_strobe. Synchronous active-low reset clears the sum and
// control; weights are undefined until written. There is no output stall.
module sparse_dense_dot_axpy #(
  parameter int DIM = sdad_pkg::DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sdad_pkg::sdad_in_t  in_word,
  output logic               out_strobe,
  output sdad_pkg::sdad_out_t out_word
);

  import sdad_pkg::*;

  localparam int AW = $clog2(DIM);

  localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};
  localparam logic signed [31:0] MAX32 = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] MIN32 = {1'b1, {31{1'b0}}};

  sdad_state_t state_r, state_nxt;

  sdad_in_t           item_r;
  logic [AW-1:0]      slot_r;
  logic               valid_r;
  logic signed [31:0] w_r;
  logic signed [47:0] prod_r;
  logic signed [47:0] sum_r, sum_nxt;
  logic               fwd_r;
  logic [31:0]        fwd_data_r;
  logic               out_strobe_r;
  sdad_out_t          out_r;

  logic               accept;
  logic               rd_en;
  logic               mul_en;
  logic               exec_en;
  logic               in_valid;
  logic [AW-1:0]      in_slot;
  logic [31:0]        ram_rdata;
  logic               ram_we;
  logic [31:0]        ram_wdata;
  logic signed [31:0] w_rd;
  logic signed [31:0] mul_a;
  logic signed [63:0] prod_full;
  logic signed [48:0] sum_ext;
  logic signed [48:0] w_ext;
  logic signed [47:0] sum_sat;
  logic signed [31:0] w_sat;

  assign accept   = start && !busy;
  assign in_valid = (in_word.index != '0) && (32'(in_word.index) <= 32'(DIM));
  assign in_slot  = AW'(in_word.index - 13'd1);

  // fsm
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: state_nxt = accept ? ST_READ : ST_IDLE;
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = accept ? ST_READ : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    rd_en   = 1'b0;
    mul_en  = 1'b0;
    exec_en = 1'b0;
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_READ: begin
        busy  = 1'b1;
        rd_en = 1'b1;
      end
      ST_MUL: begin
        busy   = 1'b1;
        mul_en = 1'b1;
      end
      ST_EXEC: exec_en = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // weight store
  sdad_ram #(
    .WIDTH (32),
    .DEPTH (DIM)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (slot_r),
    .wdata   (ram_wdata),
    .raddr   (in_slot),
    .rdata_r (ram_rdata)
  );

  // read stage; forward a write to the same slot issued alongside the read
  always_comb begin
    w_rd = fwd_r ? $signed(fwd_data_r) : $signed(ram_rdata);
    if (!valid_r) begin
      w_rd = '0;
    end
  end

  // multiply stage
  always_comb begin
    mul_a     = (item_r.op == OP_DOT) ? w_r : item_r.scale;
    prod_full = mul_a * item_r.value;
  end

  // execute stage
  always_comb begin
    sum_ext = {sum_r[47], sum_r} + {prod_r[47], prod_r};
    if (sum_ext > 49'sh0_7FFF_FFFF_FFFF) begin
      sum_sat = MAX48;
    end else if (sum_ext < -49'sh0_8000_0000_0000) begin
      sum_sat = MIN48;
    end else begin
      sum_sat = sum_ext[47:0];
    end

    w_ext = 49'(w_r) + {prod_r[47], prod_r};
    if (w_ext > 49'(MAX32)) begin
      w_sat = MAX32;
    end else if (w_ext < 49'(MIN32)) begin
      w_sat = MIN32;
    end else begin
      w_sat = w_ext[31:0];
    end

    ram_we    = 1'b0;
    ram_wdata = item_r.value;
    sum_nxt   = sum_r;
    if (exec_en) begin
      case (item_r.op)
        OP_WRITE: ram_we = valid_r;
        OP_READ:  ram_we = 1'b0;
        OP_DOT: begin
          sum_nxt = item_r.last ? '0 : sum_sat;
        end
        OP_ADD: begin
          ram_we    = valid_r;
          ram_wdata = w_sat;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sum_r        <= '0;
      fwd_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      fwd_r        <= accept && ram_we && (slot_r == in_slot);
      out_strobe_r <= exec_en && ((item_r.op == OP_READ) ||
                                  (item_r.op == OP_DOT && item_r.last));
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= ram_wdata;
    if (accept) begin
      item_r  <= in_word;
      slot_r  <= in_slot;
      valid_r <= in_valid;
    end
    if (rd_en) begin
      w_r <= w_rd;
    end
    if (mul_en) begin
      prod_r <= prod_full[63:16];
    end
    if (exec_en) begin
      if (item_r.op == OP_DOT) begin
        out_r.kind   <= KIND_DOT;
        out_r.result <= sum_sat;
      end else begin
        out_r.kind   <= KIND_WEIGHT;
        out_r.result <= 48'(w_r);
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

  a_accept_read : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_READ)
    else $error("accepted word did not enter read stage");

  a_strobe_src : assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_EXEC |=> !out_strobe_r)
    else $error("result strobe without execute");

  a_we_exec : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_EXEC)
    else $error("weight write outside execute");

  a_sum_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (exec_en && item_r.op == OP_DOT && item_r.last) |=> sum_r == '0)
    else $error("sum not cleared after last element");

endmodule

>>> rtl/sdad_ram.sv
module sdad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
